@@ hdl/lcrc_pkg.sv @@
// Shared types and constants for the length-chained record classifier.
// No dependencies; the classifier modules import this package.
`default_nettype none

package lcrc_pkg;

	localparam logic [7:0] RECORD_MARK = 8'hf7;
	localparam logic [7:0] ALT_MARK    = 8'hff;
	localparam logic [7:0] SHORT_MARK  = 8'h01;

	localparam logic [15:0] MAX_RECORD_LEN_RESET = 16'd1500;
	localparam logic [15:0] DETECT_AFTER_RESET   = 16'd2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic {
		REG_MAX_RECORD_LEN = 1'b0,
		REG_DETECT_AFTER   = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		VERDICT_WAIT     = 2'd0,
		VERDICT_DETECTED = 2'd1,
		VERDICT_EXCLUDED = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [15:0] max_record_len;
		logic [15:0] detect_after;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] flow_packet_count;
	} item_t;

endpackage

`default_nettype wire

@@ hdl/lcrc_in_if.sv @@
// Payload byte channel: valid/ready handshake plus one byte and its packet context.
// No dependencies.
`default_nettype none

interface lcrc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [15:0] flow_packet_count;

	modport source (output valid, output data_byte, output last_byte,
		output flow_packet_count, input ready);
	modport sink (input valid, input data_byte, input last_byte,
		input flow_packet_count, output ready);
endinterface

`default_nettype wire

@@ hdl/lcrc_out_if.sv @@
// Verdict channel: valid/ready handshake plus the 2-bit verdict.
// No dependencies.
`default_nettype none

interface lcrc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

`default_nettype wire

@@ hdl/lcrc_cfg_regs.sv @@
// APB-style configuration registers: max_record_len at 0x0, detect_after at 0x4.
// Depends on lcrc_pkg.
`default_nettype none

module lcrc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lcrc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lcrc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lcrc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output lcrc_pkg::cfg_t                  cfg
);
	import lcrc_pkg::*;

	cfg_t       cfg_q;
	reg_index_t reg_sel;
	logic       wr_en;

	// word select only; byte offset bits are ignored
	assign reg_sel = reg_index_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_record_len <= MAX_RECORD_LEN_RESET;
			cfg_q.detect_after   <= DETECT_AFTER_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MAX_RECORD_LEN: cfg_q.max_record_len <= pwdata[15:0];
				REG_DETECT_AFTER:   cfg_q.detect_after   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MAX_RECORD_LEN: prdata = {16'd0, cfg_q.max_record_len};
			REG_DETECT_AFTER:   prdata = {16'd0, cfg_q.detect_after};
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/lcrc_chain.sv @@
// Per-packet record-chain tracker: position, chain pointer, header bytes, break flag,
// and the verdict for the current byte. Depends on lcrc_pkg.
`default_nettype none

module lcrc_chain #(
	parameter int POSITION_BITS    = 16,
	parameter int EARLY_BYTE_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  lcrc_pkg::item_t    item,
	input  lcrc_pkg::cfg_t     cfg,
	output lcrc_pkg::verdict_t verdict
);
	import lcrc_pkg::*;

	localparam int SUM_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
	localparam logic [POSITION_BITS-1:0] POS_MASK = {POSITION_BITS{1'b1}};

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] nrs_q;
	logic [7:0]               early_q [EARLY_BYTE_COUNT];
	logic [7:0]               low_q;
	logic                     broken_q;
	logic                     flag_q;

	logic [7:0]               cur;
	logic [15:0]              start_word;
	logic [15:0]              rec_len;
	logic [POSITION_BITS-1:0] nrs_a;
	logic [POSITION_BITS-1:0] nrs_n;
	logic [SUM_W-1:0]         rec_sum;
	logic                     rec_hit;
	logic [7:0]               head_byte;
	logic                     brk;
	logic                     flag_n;

	assign cur        = item.data_byte;
	assign start_word = {cur, early_q[2]};
	assign rec_len    = {cur, low_q};
	assign nrs_a      = (pos_q == POSITION_BITS'(3)) ? start_word[POSITION_BITS-1:0] : nrs_q;
	assign rec_sum    = SUM_W'(nrs_a) + SUM_W'(rec_len);
	// length field of the current record ends on this byte
	assign rec_hit    = (SUM_W'(nrs_a) + SUM_W'(3)) == SUM_W'(pos_q);

	// records starting inside the header read their mark from the kept bytes
	always_comb begin
		case (nrs_a[1:0])
			2'd0:    head_byte = early_q[0];
			2'd1:    head_byte = early_q[1];
			2'd2:    head_byte = early_q[2];
			default: head_byte = early_q[3];
		endcase
	end

	always_comb begin
		brk    = broken_q || (pos_q == POS_MASK);
		flag_n = flag_q;
		nrs_n  = nrs_a;
		if (pos_q == '0) begin
			flag_n = (cur == SHORT_MARK);
			if (cur != RECORD_MARK && cur != ALT_MARK)
				brk = 1'b1;
		end
		if (pos_q == POSITION_BITS'(3) && SUM_W'(start_word) > SUM_W'(POS_MASK))
			brk = 1'b1;
		if (pos_q >= POSITION_BITS'(3) && !brk) begin
			if (pos_q > POSITION_BITS'(3) && nrs_a == pos_q && cur != RECORD_MARK)
				brk = 1'b1;
			if (!brk && rec_hit) begin
				if (nrs_a < POSITION_BITS'(4) && head_byte != RECORD_MARK)
					brk = 1'b1;
				else if (rec_len < 16'd3 || rec_len > cfg.max_record_len)
					brk = 1'b1;
				else if (rec_sum > SUM_W'(POS_MASK))
					brk = 1'b1;
				else begin
					nrs_n = rec_sum[POSITION_BITS-1:0];
					if (nrs_n == pos_q && cur != RECORD_MARK)
						brk = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (pos_q == '0)
			verdict = (flag_n && item.flow_packet_count == 16'd1) ?
				VERDICT_WAIT : VERDICT_EXCLUDED;
		else if (pos_q < POSITION_BITS'(3) || brk)
			verdict = VERDICT_EXCLUDED;
		else if (SUM_W'(nrs_n) == SUM_W'(pos_q) + SUM_W'(1))
			verdict = (item.flow_packet_count > cfg.detect_after) ?
				VERDICT_DETECTED : VERDICT_WAIT;
		else
			verdict = VERDICT_EXCLUDED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			nrs_q    <= '0;
			low_q    <= '0;
			broken_q <= 1'b0;
			flag_q   <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q    <= '0;
				nrs_q    <= '0;
				low_q    <= '0;
				broken_q <= 1'b0;
				flag_q   <= 1'b0;
			end else begin
				// position saturates; the saturated value itself marks a break
				if (pos_q != POS_MASK)
					pos_q <= pos_q + POSITION_BITS'(1);
				nrs_q    <= nrs_n;
				low_q    <= cur;
				broken_q <= brk;
				flag_q   <= flag_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < EARLY_BYTE_COUNT; i++) begin
			if (step && pos_q == POSITION_BITS'(i))
				early_q[i] <= cur;
		end
	end

endmodule

`default_nettype wire

@@ hdl/length_chained_record_classifier_top.sv @@
// Length-chained record classifier: one payload byte per cycle, one verdict per packet;
// a last byte waits while an untaken verdict is held, then its verdict is registered.
// Throughput: one byte per cycle but for that wait, set by the chain tracker's update;
// the verdict register lets the next packet's bytes flow while a verdict waits.
// Reset (arst_n, async, active low): registers to defaults, per-packet state cleared,
// kept header bytes not reset. Depends on lcrc_pkg, lcrc_in_if, lcrc_out_if.
`default_nettype none

module length_chained_record_classifier_top #(
	parameter int POSITION_BITS    = 16,
	parameter int EARLY_BYTE_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lcrc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lcrc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lcrc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	lcrc_in_if.sink                         payload,
	lcrc_out_if.source                      result
);
	import lcrc_pkg::*;

	cfg_t     cfg;
	item_t    item_s1;
	logic     valid_s1;
	verdict_t verdict_s2;
	logic     valid_s2;
	verdict_t verdict_n;
	logic     step;

	lcrc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcrc_chain #(
		.POSITION_BITS    (POSITION_BITS),
		.EARLY_BYTE_COUNT (EARLY_BYTE_COUNT)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.cfg     (cfg),
		.verdict (verdict_n)
	);

	// mid-packet bytes never wait; a last byte needs a free verdict slot
	assign step          = valid_s1 && (!item_s1.last_byte || !valid_s2 || result.ready);
	assign payload.ready = !valid_s1 || step;
	assign result.valid  = valid_s2;
	assign result.verdict = verdict_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (payload.ready)
				valid_s1 <= payload.valid;
			if (step && item_s1.last_byte)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.valid && payload.ready) begin
			item_s1.data_byte         <= payload.data_byte;
			item_s1.last_byte         <= payload.last_byte;
			item_s1.flow_packet_count <= payload.flow_packet_count;
		end
		if (step && item_s1.last_byte)
			verdict_s2 <= verdict_n;
	end

endmodule

`default_nettype wire
